// ----- sv/erb_pkg.sv -----
// shared types and constants for the evicting record ring buffer
// no dependencies; imported by every module of the block
`default_nettype none

package erb_pkg;

    // fixed field widths
    localparam int LEN_W     = 10;
    localparam int BYTE_W    = 8;
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 1;

    // default geometry
    localparam int DEF_CAPACITY     = 1024;
    localparam int DEF_HEADER_BYTES = 2;

    // item kinds
    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_READ   = 2'd1,
        KIND_DROP   = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic clear;
        logic reject;
        logic drop;
        logic evict;
        logic hl_issue;
        logic hl_cap;
        logic hdr_wr;
        logic zero_wr;
        logic commit;
        logic append;
        logic rd_issue;
        logic rd_cap;
        logic err;
        logic step_clr;
        logic step_inc;
        logic out_load;
    } erb_cmd_t;

    // datapath to controller status
    typedef struct packed {
        kind_t kind;
        logic  first;
        logic  too_long;
        logic  fits;
        logic  cnt_zero;
        logic  off_bad;
        logic  step_hdr_last;
        logic  zero_done;
        logic  out_free;
    } erb_stat_t;

endpackage

`default_nettype wire

// ----- sv/erb_dpath.sv -----
// datapath: byte store, pointers, counters, item and result registers
// depends on erb_pkg; driven by erb_ctrl through erb_cmd_t
`default_nettype none

module erb_dpath
    import erb_pkg::*;
#(
    parameter int CAPACITY     = DEF_CAPACITY,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire erb_cmd_t             cmd,
    output erb_stat_t                 stat,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic [S_TUSER_W-1:0] s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic [M_TUSER_W-1:0]      m_tuser
);

    localparam int PTR_W    = $clog2(CAPACITY);
    localparam int USED_W   = $clog2(CAPACITY + 1);
    localparam int SUM_W    = ((USED_W > 11) ? USED_W : 11) + 1;
    localparam int HDR_BITS = 8 * HEADER_BYTES;

    // wrap a sum below twice the capacity back into the ring
    function automatic logic [PTR_W-1:0] wrap_ptr(input logic [SUM_W-1:0] x);
        logic [SUM_W-1:0] y;
        begin
            y = (x >= SUM_W'(CAPACITY)) ? x - SUM_W'(CAPACITY) : x;
            return y[PTR_W-1:0];
        end
    endfunction

    // item registers
    kind_t             kind_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              first_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  off_reg;

    // ring state
    logic [PTR_W-1:0]  rp_reg;
    logic [PTR_W-1:0]  wp_reg;
    logic [USED_W-1:0] used_reg;
    logic [USED_W-1:0] cnt_reg;
    logic [LEN_W-1:0]  bl_reg;
    logic              drop_reg;
    logic [LEN_W-1:0]  hlen_reg;
    logic [LEN_W-1:0]  step_reg;

    // result in progress
    logic [USED_W-1:0] evict_reg;
    logic              err_reg;
    logic [BYTE_W-1:0] rbyte_reg;

    // output register
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic                 out_err_reg;

    // memory port
    logic [BYTE_W-1:0] mem [CAPACITY];
    logic [BYTE_W-1:0] rdata_reg;
    logic              mem_we;
    logic [PTR_W-1:0]  mem_addr;
    logic [BYTE_W-1:0] mem_wdata;

    // derived values
    logic [SUM_W-1:0]  need;
    logic [SUM_W-1:0]  free_sum;
    logic [SUM_W-1:0]  drop_total;
    logic [SUM_W-1:0]  drop_raw;
    logic [31:0]       len32;
    logic              len_hdr_bad;
    logic [USED_W-1:0] cnt_dec;
    logic [LEN_W-1:0]  bl_dec;
    logic [4:0]        byte_shift;

    assign need       = SUM_W'(HEADER_BYTES) + SUM_W'(len_reg);
    assign free_sum   = SUM_W'(CAPACITY) - SUM_W'(used_reg);
    assign drop_raw   = SUM_W'(HEADER_BYTES) + SUM_W'(hlen_reg);
    assign drop_total = (drop_raw > SUM_W'(used_reg)) ? SUM_W'(used_reg) : drop_raw;
    assign len32      = 32'(len_reg);
    assign len_hdr_bad = (HDR_BITS < LEN_W) && ((len32 >> HDR_BITS) != 32'd0);
    assign cnt_dec    = cnt_reg - USED_W'(1);
    assign bl_dec     = bl_reg - LEN_W'(1);
    assign byte_shift = {step_reg[1:0], 3'b000};

    // status toward the controller
    assign stat.kind          = kind_reg;
    assign stat.first         = first_reg;
    assign stat.too_long      = (need > SUM_W'(CAPACITY)) || len_hdr_bad;
    assign stat.fits          = free_sum >= need;
    assign stat.cnt_zero      = (cnt_reg == '0);
    assign stat.off_bad       = (off_reg >= hlen_reg);
    assign stat.step_hdr_last = (step_reg == LEN_W'(HEADER_BYTES - 1));
    assign stat.zero_done     = (step_reg == len_reg);
    assign stat.out_free      = !out_valid_reg || m_tready;

    // memory address and write data select
    always_comb
    begin
        mem_we    = 1'b0;
        mem_wdata = '0;
        mem_addr  = wrap_ptr(SUM_W'(rp_reg) + SUM_W'(step_reg));
        if (cmd.hdr_wr)
        begin
            mem_we    = 1'b1;
            mem_wdata = BYTE_W'(len32 >> byte_shift);
            mem_addr  = wrap_ptr(SUM_W'(wp_reg) + SUM_W'(step_reg));
        end
        else if (cmd.zero_wr)
        begin
            mem_we   = 1'b1;
            mem_addr = wrap_ptr(SUM_W'(wp_reg) + SUM_W'(HEADER_BYTES) + SUM_W'(step_reg));
        end
        else if (cmd.append)
        begin
            mem_we    = (bl_reg != '0) && !drop_reg;
            mem_wdata = byte_reg;
            mem_addr  = wrap_ptr(SUM_W'(wp_reg) + SUM_W'(CAPACITY) - SUM_W'(bl_reg));
        end
        else if (cmd.rd_issue)
        begin
            mem_addr = wrap_ptr(SUM_W'(rp_reg) + SUM_W'(HEADER_BYTES) + SUM_W'(off_reg));
        end
        else if (cmd.hl_issue)
        begin
            // header byte of the current head
            mem_addr = wrap_ptr(SUM_W'(rp_reg) + SUM_W'(step_reg));
        end
    end

    // byte store, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_addr];
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= kind_t'(s_tuser[1:0]);
            first_reg <= s_tuser[2];
            byte_reg  <= s_tdata[7:0];
            len_reg   <= s_tdata[17:8];
            off_reg   <= s_tdata[27:18];
        end
    end

    // ring state and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg        <= '0;
            wp_reg        <= '0;
            used_reg      <= '0;
            cnt_reg       <= '0;
            bl_reg        <= '0;
            drop_reg      <= 1'b0;
            hlen_reg      <= '0;
            step_reg      <= '0;
            evict_reg     <= '0;
            err_reg       <= 1'b0;
            rbyte_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_err_reg   <= 1'b0;
        end
        else
        begin
            // step counter
            if (cmd.step_clr)
            begin
                step_reg <= '0;
            end
            else if (cmd.step_inc)
            begin
                step_reg <= step_reg + LEN_W'(1);
            end

            // result fields start clean for each item
            if (cmd.load)
            begin
                evict_reg <= '0;
                err_reg   <= 1'b0;
                rbyte_reg <= '0;
            end
            if (cmd.err || cmd.reject)
            begin
                err_reg <= 1'b1;
            end

            if (cmd.clear)
            begin
                rp_reg   <= '0;
                wp_reg   <= '0;
                used_reg <= '0;
                cnt_reg  <= '0;
                bl_reg   <= '0;
                drop_reg <= 1'b0;
                hlen_reg <= '0;
            end

            // refused record: count its bytes away
            if (cmd.reject)
            begin
                drop_reg <= 1'b1;
                bl_reg   <= (len_reg != '0) ? len_reg - LEN_W'(1) : len_reg;
            end

            // remove the oldest record, header reloads after
            if (cmd.drop || cmd.evict)
            begin
                rp_reg   <= wrap_ptr(SUM_W'(rp_reg) + drop_total);
                used_reg <= used_reg - USED_W'(drop_total);
                cnt_reg  <= cnt_dec;
                hlen_reg <= '0;
                if (cnt_dec == '0 && bl_reg != '0)
                begin
                    drop_reg <= 1'b1;
                end
            end
            if (cmd.evict)
            begin
                evict_reg <= evict_reg + USED_W'(1);
            end

            // gather header bytes of the new head
            if (cmd.hl_cap)
            begin
                hlen_reg <= hlen_reg | LEN_W'(32'(rdata_reg) << byte_shift);
            end

            // reservation done
            if (cmd.commit)
            begin
                wp_reg   <= wrap_ptr(SUM_W'(wp_reg) + need);
                used_reg <= used_reg + USED_W'(need);
                cnt_reg  <= cnt_reg + USED_W'(1);
                bl_reg   <= len_reg;
                drop_reg <= 1'b0;
                if (cnt_reg == '0)
                begin
                    hlen_reg <= len_reg;
                end
            end

            // payload byte
            if (cmd.append && bl_reg != '0)
            begin
                bl_reg <= bl_dec;
                if (bl_dec == '0)
                begin
                    drop_reg <= 1'b0;
                end
            end

            if (cmd.rd_cap)
            begin
                rbyte_reg <= rdata_reg;
            end

            // output beat
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= {7'd0,
                                  LEN_W'(evict_reg),
                                  11'(SUM_W'(CAPACITY) - SUM_W'(used_reg)),
                                  LEN_W'(cnt_reg),
                                  hlen_reg,
                                  rbyte_reg};
                out_err_reg   <= err_reg;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_err_reg;

endmodule

`default_nettype wire

// ----- sv/erb_ctrl.sv -----
// controller state machine sequencing one item at a time
// depends on erb_pkg; commands erb_dpath
`default_nettype none

module erb_ctrl
    import erb_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire erb_stat_t stat,
    output erb_cmd_t       cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_EV_CHECK,
        ST_HL_ISSUE,
        ST_HL_CAP,
        ST_HDR_WR,
        ST_ZERO,
        ST_COMMIT,
        ST_APPEND,
        ST_RD_CAP,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    state_t hl_return;

    // after a header reload an append goes back to the room check
    assign hl_return = (stat.kind == KIND_APPEND) ? ST_EV_CHECK : ST_DONE;
    assign s_tready  = (state_reg == ST_IDLE);

    // next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (stat.kind)
                    KIND_APPEND:
                    begin
                        if (!stat.first)
                        begin
                            state_next = ST_APPEND;
                        end
                        else if (stat.too_long)
                        begin
                            cmd.reject = 1'b1;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_EV_CHECK;
                        end
                    end
                    KIND_READ:
                    begin
                        if (stat.cnt_zero || stat.off_bad)
                        begin
                            cmd.err    = 1'b1;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            cmd.rd_issue = 1'b1;
                            state_next   = ST_RD_CAP;
                        end
                    end
                    KIND_DROP:
                    begin
                        if (stat.cnt_zero)
                        begin
                            cmd.err    = 1'b1;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            cmd.drop     = 1'b1;
                            cmd.step_clr = 1'b1;
                            state_next   = ST_HL_ISSUE;
                        end
                    end
                    default:
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_EV_CHECK:
            begin
                cmd.step_clr = 1'b1;
                if (stat.fits || stat.cnt_zero)
                begin
                    state_next = ST_HDR_WR;
                end
                else
                begin
                    cmd.evict  = 1'b1;
                    state_next = ST_HL_ISSUE;
                end
            end
            ST_HL_ISSUE:
            begin
                if (stat.cnt_zero)
                begin
                    state_next = hl_return;
                end
                else
                begin
                    cmd.hl_issue = 1'b1;
                    state_next   = ST_HL_CAP;
                end
            end
            ST_HL_CAP:
            begin
                cmd.hl_cap   = 1'b1;
                cmd.step_inc = 1'b1;
                state_next   = stat.step_hdr_last ? hl_return : ST_HL_ISSUE;
            end
            ST_HDR_WR:
            begin
                cmd.hdr_wr = 1'b1;
                if (stat.step_hdr_last)
                begin
                    cmd.step_clr = 1'b1;
                    state_next   = ST_ZERO;
                end
                else
                begin
                    cmd.step_inc = 1'b1;
                end
            end
            ST_ZERO:
            begin
                if (stat.zero_done)
                begin
                    state_next = ST_COMMIT;
                end
                else
                begin
                    cmd.zero_wr  = 1'b1;
                    cmd.step_inc = 1'b1;
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_APPEND;
            end
            ST_APPEND:
            begin
                cmd.append = 1'b1;
                state_next = ST_DONE;
            end
            ST_RD_CAP:
            begin
                cmd.rd_cap = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/evicting_record_ring_buffer_unit.sv -----
// Ring store of variable-length records that drops the oldest records when a new
// one needs room. One item is handled at a time; every header write, payload zeroing
// and header reload goes through the single port of the byte store, and the last
// step of an item is held for as long as the previous result waits unread.
// The result register lets the next item be taken while a result is pending.
// depends on erb_pkg, erb_ctrl, erb_dpath
`default_nettype none

module evicting_record_ring_buffer_unit
    import erb_pkg::*;
#(
    parameter int CAPACITY     = DEF_CAPACITY,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // data_byte [7:0], record_length [17:8], read_offset [27:18], zero fill
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // kind [1:0], first_of_record [2]
    input  wire logic [S_TUSER_W-1:0] s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // read_byte [7:0], head_length [17:8], record_count [27:18],
    // free_bytes [38:28], evicted [48:39], zero fill
    output logic [M_TDATA_W-1:0]      m_tdata,
    // error [0]
    output logic [M_TUSER_W-1:0]      m_tuser
);

    erb_cmd_t  cmd;
    erb_stat_t stat;

    // sequencer
    erb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // store and registers
    erb_dpath #(
        .CAPACITY     (CAPACITY),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // one item in flight: no beat taken right after another
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in progress");

    // a failed item never returns a read byte
    a_err_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[7:0] == 8'd0)
        else $error("read byte nonzero on error");

    // evictions only happen for an accepted record
    a_evict_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[48:39] != 10'd0 |-> !m_tuser[0])
        else $error("eviction reported with error");

endmodule

`default_nettype wire

// ----- tb/evicting_record_ring_buffer_unit_test.sv -----
// self-checking testbench for evicting_record_ring_buffer_unit: random and directed
// stream beats, a record-store predictor in a scoreboard class, randomized stalls
// depends on erb_pkg and the unit's rtl only
`default_nettype none

module evicting_record_ring_buffer_unit_test;
    import erb_pkg::*;

    localparam int CAP = DEF_CAPACITY;
    localparam int HDR = DEF_HEADER_BYTES;

    typedef struct {
        bit [7:0]  rd_byte;
        bit [9:0]  head_len;
        bit [9:0]  rec_count;
        bit [10:0] free;
        bit [9:0]  evicted;
        bit        err;
    } status_t;

    // record store predictor and queue of expected status beats
    class record_store_board;
        bit [7:0]    mem [CAP];
        int unsigned rd_ptr, wr_ptr, used, recs, left;
        bit          discarding;
        status_t     expected_q [$];
        int          fails;

        function void clear_state();
            rd_ptr = 0;
            wr_ptr = 0;
            used = 0;
            recs = 0;
            left = 0;
            discarding = 0;
        endfunction

        function int unsigned head_len();
            int unsigned v;
            v = 0;
            if (recs != 0)
                for (int i = 0; i < HDR; i++)
                    v |= int'(mem[(rd_ptr + i) % CAP]) << (8 * i);
            return v;
        endfunction

        function void drop_oldest();
            int unsigned total;
            total = HDR + head_len();
            if (total > used)
                total = used;
            rd_ptr = (rd_ptr + total) % CAP;
            used -= total;
            recs--;
            if (recs == 0 && left != 0)
                discarding = 1;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_input(kind_t k, bit [7:0] d, bit f, bit [9:0] len, bit [9:0] off);
            status_t     s;
            int unsigned need;
            bit          refused;
            s = '{default: 0};
            refused = 0;
            case (k)
                KIND_APPEND:
                begin
                    if (f)
                    begin
                        need = HDR + len;
                        if (need > CAP)
                        begin
                            // too long: refuse and swallow the rest of its bytes
                            s.err = 1;
                            refused = 1;
                            left = len;
                            discarding = 1;
                            if (left != 0)
                                left--;
                        end
                        else
                        begin
                            // evict oldest until the whole record fits
                            while (CAP - used < need && recs != 0)
                            begin
                                drop_oldest();
                                s.evicted++;
                            end
                            for (int i = 0; i < HDR; i++)
                                mem[(wr_ptr + i) % CAP] = 8'((len >> (8 * i)) & 8'hff);
                            for (int i = 0; i < len; i++)
                                mem[(wr_ptr + HDR + i) % CAP] = 8'h00;
                            wr_ptr = (wr_ptr + need) % CAP;
                            used += need;
                            recs++;
                            left = len;
                            discarding = 0;
                        end
                    end
                    // payload byte into the open record
                    if (!refused && left != 0)
                    begin
                        if (!discarding)
                            mem[(wr_ptr + CAP - left) % CAP] = d;
                        left--;
                        if (left == 0)
                            discarding = 0;
                    end
                end
                KIND_READ:
                begin
                    if (recs == 0 || off >= head_len())
                        s.err = 1;
                    else
                        s.rd_byte = mem[(rd_ptr + HDR + off) % CAP];
                end
                KIND_DROP:
                begin
                    if (recs == 0)
                        s.err = 1;
                    else
                        drop_oldest();
                end
                default:
                    clear_state();
            endcase
            s.head_len  = 10'(head_len());
            s.rec_count = 10'(recs);
            s.free      = 11'(CAP - used);
            expected_q.push_back(s);
        endfunction

        function void check(bit [M_TDATA_W-1:0] td, bit [M_TUSER_W-1:0] tu);
            status_t e;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result beat %h", td);
                fails++;
                return;
            end
            e = expected_q.pop_front();
            if (td[7:0] != e.rd_byte)
            begin
                $error("read_byte exp %0d got %0d", e.rd_byte, td[7:0]);
                fails++;
            end
            if (td[17:8] != e.head_len)
            begin
                $error("head_length exp %0d got %0d", e.head_len, td[17:8]);
                fails++;
            end
            if (td[27:18] != e.rec_count)
            begin
                $error("record_count exp %0d got %0d", e.rec_count, td[27:18]);
                fails++;
            end
            if (td[38:28] != e.free)
            begin
                $error("free_bytes exp %0d got %0d", e.free, td[38:28]);
                fails++;
            end
            if (td[48:39] != e.evicted)
            begin
                $error("evicted exp %0d got %0d", e.evicted, td[48:39]);
                fails++;
            end
            if (tu[0] != e.err)
            begin
                $error("error exp %0d got %0d", e.err, tu[0]);
                fails++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    record_store_board sb;
    bit quiet;
    bit long_hold_req;
    int beats_sent;
    int stall_left;

    evicting_record_ring_buffer_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end

    // receiver side: random stall bursts plus one long hold-off on request
    initial
    begin
        m_tready = 0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                stall_left = 300;
                long_hold_req = 0;
            end
            if (stall_left > 0)
            begin
                m_tready <= 0;
                stall_left--;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 0;
                stall_left = $urandom_range(0, 5);
            end
            else
                m_tready <= 1;
        end
    end

    // result check on each accepted beat
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check(m_tdata, m_tuser);

    // one input beat, with an optional idle burst before it
    task automatic send_beat(kind_t k, bit [7:0] d, bit f, bit [9:0] len, bit [9:0] off);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata  <= {4'b0, off, len, d};
        s_tuser  <= {f, k};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(k, d, f, len, off);
        beats_sent++;
    endtask

    // record start plus nbytes-1 following payload bytes
    task automatic send_record(bit [9:0] len, int nbytes);
        send_beat(KIND_APPEND, 8'($urandom), 1, len, 10'($urandom));
        for (int i = 1; i < nbytes; i++)
            send_beat(KIND_APPEND, 8'($urandom), 0, 10'($urandom), 10'($urandom));
    endtask

    task automatic send_read(bit [9:0] off);
        send_beat(KIND_READ, 8'($urandom), 0, 10'($urandom), off);
    endtask

    task automatic send_op(kind_t k);
        send_beat(k, 8'($urandom), 1'($urandom), 10'($urandom), 10'($urandom));
    endtask

    // stimulus
    initial
    begin
        int unsigned hl;
        int unsigned pick;
        int unsigned len;
        sb = new();
        sb.clear_state();
        sb.fails = 0;
        quiet = 0;
        long_hold_req = 0;
        beats_sent = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: empty store, stray byte, edge lengths, open-record cases
        send_read(10'd0);
        send_op(KIND_DROP);
        send_beat(KIND_APPEND, 8'hff, 0, 10'd5, 10'd0);
        send_record(10'd0, 1);
        send_record(10'd3, 3);
        send_read(10'd0);
        send_read(10'd2);
        send_read(10'd3);
        send_read(10'd1023);
        send_record(10'd1023, 3);
        send_record(10'd1022, 2);
        send_read(10'd1021);
        send_read(10'd0);
        send_record(10'd4, 2);
        send_op(KIND_DROP);
        send_beat(KIND_APPEND, 8'h00, 0, 10'd0, 10'd0);
        send_op(KIND_DROP);
        send_op(KIND_DROP);
        send_op(KIND_CLEAR);
        send_read(10'd0);

        // random: mostly well-formed records with reads between them
        while (beats_sent < 670)
        begin
            if (beats_sent >= 200 && beats_sent < 205)
                long_hold_req = 1;
            if (beats_sent >= 400 && beats_sent < 405 && sb.pending() != 0)
            begin
                // sender quiet until every result is back
                s_tvalid <= 0;
                while (sb.pending() != 0)
                    @(posedge clk);
            end
            if (beats_sent >= 600)
                quiet = 1;
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                len = $urandom_range(0, 99) < 4 ? $urandom_range(100, 1023)
                                                : $urandom_range(0, 30);
                if (len > 40 || $urandom_range(0, 9) == 0)
                    send_record(10'(len), $urandom_range(1, 6));
                else
                    send_record(10'(len), len == 0 ? 1 : len);
            end
            else if (pick < 80)
            begin
                hl = sb.head_len();
                if (hl != 0 && $urandom_range(0, 5) != 0)
                    send_read(10'($urandom_range(0, hl - 1)));
                else
                    send_read(10'($urandom));
            end
            else if (pick < 92)
                send_op(KIND_DROP);
            else if (pick < 95)
                send_op(KIND_CLEAR);
            else
                send_beat(KIND_APPEND, 8'($urandom), 0, 10'($urandom), 10'($urandom));
        end
        s_tvalid <= 0;

        // drain
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.fails == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
sv/erb_pkg.sv
sv/erb_dpath.sv
sv/erb_ctrl.sv
sv/evicting_record_ring_buffer_unit.sv
tb/evicting_record_ring_buffer_unit_test.sv
